### rtl/gda_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date adder.
`timescale 1ns / 1ps

package gda_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int STAT_W  = 2;
	localparam int R400_W  = 9;
	localparam int Q400_W  = 6;

	localparam logic [YEAR_W-1:0]  MAX_YEAR        = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
	localparam logic [R400_W-1:0]  LEAP_CYCLE_LAST = 9'd399;

	// floor(x/12) is (x*RECIP12) >> RECIP12_SHIFT for every x below 2**32.
	localparam logic [31:0] RECIP12       = 32'hAAAAAAAB;
	localparam int          RECIP12_SHIFT = 35;
	// floor(y/400) is (y*RECIP400) >> RECIP400_SHIFT for every 14-bit year.
	localparam logic [12:0] RECIP400       = 13'd5243;
	localparam int          RECIP400_SHIFT = 21;

	localparam logic [1:0] FUNC_ADD_DAYS   = 2'd0;
	localparam logic [1:0] FUNC_ADD_MONTHS = 2'd1;
	localparam logic [1:0] FUNC_ADD_YEARS  = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_INVALID  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} gda_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic rem_step;
		logic check;
		logic walk;
		logic out_load;
	} gda_cmd_t;

	typedef struct packed {
		logic walk_needed;
		logic walk_last;
	} gda_stat_t;

	// Leap year from the year's remainder modulo 400.
	function automatic logic leap_from_r400(input logic [R400_W-1:0] r);
		logic res;
		res = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
		return res;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                               input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd2:                                     len = leap ? 5'd29 : 5'd28;
			default:                                  len = 5'd30;
		endcase
		return len;
	endfunction

endpackage

### rtl/gda_ctrl.sv
// Sequencing state machine for the Gregorian date adder.
`timescale 1ns / 1ps

module gda_ctrl import gda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      res_valid,
	input  logic      res_stall,
	input  gda_stat_t stat,
	output gda_cmd_t  cmd
);

	gda_state_t        state_q, state_d;
	logic              res_valid_q, res_valid_d;
	logic              out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		res_valid_d = res_valid_q && res_stall;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = ST_REM;
			end
			ST_REM: begin
				cmd.rem_step = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.walk_needed ? ST_WALK : ST_DONE;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					res_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/gda_dp.sv
// Datapath of the Gregorian date adder: dividers, date walk and result register.
`timescale 1ns / 1ps

module gda_dp import gda_pkg::*; #(
	parameter int AMOUNT_BITS = 16
) (
	input  logic                   clk,
	input  gda_cmd_t               cmd,
	output gda_stat_t              stat,
	input  logic [1:0]             func,
	input  logic [YEAR_W-1:0]      start_year,
	input  logic [MONTH_W-1:0]     start_month,
	input  logic [DAY_W-1:0]       start_day,
	input  logic [AMOUNT_BITS-1:0] amount,
	output logic [YEAR_W-1:0]      result_year,
	output logic [MONTH_W-1:0]     result_month,
	output logic [DAY_W-1:0]       result_day,
	output logic [STAT_W-1:0]      status
);

	localparam int SUM_W      = ((AMOUNT_BITS > YEAR_W) ? AMOUNT_BITS : YEAR_W) + 1;
	localparam int PROD12_W   = AMOUNT_BITS + RECIP12_SHIFT;
	localparam int PROD400_W  = RECIP400_SHIFT + Q400_W;

	// Captured item.
	logic [1:0]             func_q;
	logic [YEAR_W-1:0]      y0_q;
	logic [MONTH_W-1:0]     m0_q;
	logic [DAY_W-1:0]       d0_q;
	logic [AMOUNT_BITS-1:0] amt_q;

	// Reciprocal dividers: amount by 12 and year by 400.
	logic [AMOUNT_BITS-1:0] q12_q;
	logic [Q400_W-1:0]      q400_q;
	logic [MONTH_W-1:0]     rem12_q;
	logic [R400_W-1:0]      r400_q;

	// Working date.
	logic [YEAR_W-1:0]      y_q;
	logic [MONTH_W-1:0]     m_q;
	logic [DAY_W-1:0]       d_q;
	logic [AMOUNT_BITS-1:0] left_q;
	logic [STAT_W-1:0]      status_q;

	// Result register.
	logic [YEAR_W-1:0]      res_year_q;
	logic [MONTH_W-1:0]     res_month_q;
	logic [DAY_W-1:0]       res_day_q;
	logic [STAT_W-1:0]      res_status_q;

	logic [PROD12_W-1:0]    prod12;
	logic [PROD400_W-1:0]   prod400;
	logic [MONTH_W-1:0]     rem12;
	logic [R400_W-1:0]      rem400;

	logic [DAY_W-1:0]       ml0;
	logic                   invalid;
	logic                   start_over;
	logic [DAY_W-1:0]       msum;
	logic                   mcarry;
	logic [MONTH_W-1:0]     mon_new;
	logic [SUM_W-1:0]       ysum_mon;
	logic [SUM_W-1:0]       ysum_yr;

	logic [DAY_W-1:0]       ml;
	logic [DAY_W-1:0]       room;
	logic                   fits;
	logic                   wrap;
	logic                   year_end;
	logic [R400_W-1:0]      r400_inc;

	// The remainders are below 12 and 400, so only the low bits of
	// x - q*12 and y - q*400 are formed, with the products as shifted adds.
	always_comb begin
		prod12  = PROD12_W'(amt_q) * PROD12_W'(RECIP12);
		prod400 = PROD400_W'(y0_q) * PROD400_W'(RECIP400);
		rem12   = amt_q[MONTH_W-1:0] - {q12_q[0], 3'b000} - {q12_q[1:0], 2'b00};
		rem400  = y0_q[R400_W-1:0] - {q400_q[0], 8'd0} - {q400_q[1:0], 7'd0} -
		          {q400_q[4:0], 4'd0};
	end

	always_comb begin
		ml0        = month_len(m0_q, leap_from_r400(r400_q));
		invalid    = (m0_q < MONTH_JAN) || (m0_q > MONTH_DEC) ||
		             (d0_q == '0) || (d0_q > ml0);
		start_over = (y0_q > MAX_YEAR);
		msum       = DAY_W'(m0_q) + DAY_W'(rem12_q);
		mcarry     = (msum > DAY_W'(MONTH_DEC));
		mon_new    = mcarry ? MONTH_W'(msum - DAY_W'(MONTH_DEC)) : msum[MONTH_W-1:0];
		ysum_mon   = SUM_W'(y0_q) + SUM_W'(q12_q) + SUM_W'(mcarry);
		ysum_yr    = SUM_W'(y0_q) + SUM_W'(amt_q);
	end

	always_comb begin
		ml       = month_len(m_q, leap_from_r400(r400_q));
		room     = ml - d_q;
		fits     = (AMOUNT_BITS'(room) >= left_q);
		wrap     = (m_q == MONTH_DEC);
		year_end = (y_q == MAX_YEAR);
		r400_inc = (r400_q == LEAP_CYCLE_LAST) ? '0 : r400_q + 1'b1;
	end

	assign stat.walk_needed = (func_q == FUNC_ADD_DAYS) && !invalid && !start_over;
	assign stat.walk_last   = fits || (wrap && year_end);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			y0_q     <= start_year;
			m0_q     <= start_month;
			d0_q     <= start_day;
			amt_q    <= amount;
		end
		if (cmd.div_step) begin
			q12_q    <= prod12[PROD12_W-1:RECIP12_SHIFT];
			q400_q   <= prod400[PROD400_W-1:RECIP400_SHIFT];
		end
		if (cmd.rem_step) begin
			rem12_q  <= rem12;
			r400_q   <= rem400;
		end
		if (cmd.check) begin
			y_q      <= y0_q;
			m_q      <= m0_q;
			d_q      <= d0_q;
			left_q   <= amt_q;
			status_q <= STATUS_OK;
			if (invalid) begin
				status_q <= STATUS_INVALID;
			end else if (start_over) begin
				status_q <= STATUS_OVERFLOW;
			end else begin
				case (func_q)
					FUNC_ADD_MONTHS: begin
						y_q <= ysum_mon[YEAR_W-1:0];
						m_q <= mon_new;
						if (ysum_mon > SUM_W'(MAX_YEAR)) begin
							status_q <= STATUS_OVERFLOW;
						end
					end
					FUNC_ADD_YEARS: begin
						y_q <= ysum_yr[YEAR_W-1:0];
						if (ysum_yr > SUM_W'(MAX_YEAR)) begin
							status_q <= STATUS_OVERFLOW;
						end
					end
					default: begin
						// Adding days keeps the start date for the walk; the
						// unused code leaves the date as it is.
					end
				endcase
			end
		end
		if (cmd.walk) begin
			if (fits) begin
				d_q <= d_q + left_q[DAY_W-1:0];
			end else begin
				left_q <= left_q - AMOUNT_BITS'(room);
				d_q    <= '0;
				if (wrap) begin
					m_q    <= MONTH_JAN;
					y_q    <= y_q + 1'b1;
					r400_q <= r400_inc;
					if (year_end) begin
						status_q <= STATUS_OVERFLOW;
					end
				end else begin
					m_q <= m_q + 1'b1;
				end
			end
		end
		if (cmd.out_load) begin
			res_status_q <= status_q;
			if (status_q != STATUS_OK) begin
				res_year_q  <= y0_q;
				res_month_q <= m0_q;
				res_day_q   <= d0_q;
			end else begin
				res_year_q  <= y_q;
				res_month_q <= m_q;
				res_day_q   <= d_q;
			end
		end
	end

	assign result_year  = res_year_q;
	assign result_month = res_month_q;
	assign result_day   = res_day_q;
	assign status       = res_status_q;

endmodule

### rtl/gregorian_date_adder.sv
// Top level of the Gregorian date adder: adds days, months or years to a date.
`timescale 1ns / 1ps
//
// Each request item carries a start date, an operation code (func) and an
// amount; the block returns exactly one result item with the new date and a
// status (ok, invalid start date, or year overflow, where the start date is
// echoed). Both channels use valid and stall: an item moves at a rising edge
// where valid is high and stall is low.
//
// Month and year additions, invalid or out-of-range starts and the unused
// code go through the divide, remainder and check steps to the result load;
// day additions walk in between, one month per walk step, until the rest of
// the amount fits in the month or the walk passes the last year. The divide
// and remainder steps form amount/12 and year mod 400 by reciprocal
// multiplication; the day walk advances one month per cycle, so a 16-bit day
// amount walks up to about 2200 months. One item is worked on at a time;
// req_stall is high while it is.
//
// The result sits in an output register, so a new item is taken while the
// previous result still waits on a stalled receiver; the finished item then
// waits in its last step until the register frees up. Asynchronous reset
// empties the block: no result is offered and the next request is taken.

module gregorian_date_adder import gda_pkg::*; #(
	parameter int AMOUNT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             func,
	input  logic [YEAR_W-1:0]      start_year,
	input  logic [MONTH_W-1:0]     start_month,
	input  logic [DAY_W-1:0]       start_day,
	input  logic [AMOUNT_BITS-1:0] amount,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [YEAR_W-1:0]      result_year,
	output logic [MONTH_W-1:0]     result_month,
	output logic [DAY_W-1:0]       result_day,
	output logic [STAT_W-1:0]      status
);

	gda_cmd_t  cmd;
	gda_stat_t stat;

	// The controller sequences load, divide, remainder, check, walk and
	// result load.
	gda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the item, the dividers, the walking date and the
	// output register.
	gda_dp #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.start_year   (start_year),
		.start_month  (start_month),
		.start_day    (start_day),
		.amount       (amount),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.status       (status)
	);

endmodule

### tb/tb_top.sv
// Self-checking testbench for the Gregorian date adder: directed table, then random requests.
`timescale 1ns / 1ps

// The bench drives request items into the date adder through a valid/stall
// handshake. For each accepted item it queues the expected date and status,
// typed in or computed with its own calendar model. A monitor on the result
// channel compares every accepted result item, field by field, with the oldest
// queued result. Both channels idle at random, except in one calm stretch of the
// random part. Twice the request side holds off until every queued result has
// come back.

module tb_top;
	import gda_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int AMT_W      = 16;
	localparam int NUM_RANDOM = 230;
	// A 16-bit day amount walks about 2200 months.
	localparam int TAIL_CYCLES = 2500;
	// The slowest correct run is about 260 items, each a full-width day addition at worst.
	localparam int CYCLE_LIMIT = 4000000;

	// The block treats this operation code as a no-op and echoes the start date.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [AMT_W-1:0]   amount;
	} date_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [STAT_W-1:0]  stat;
	} date_res_t;

	// When typed is set, lit holds the expected result. Otherwise the calendar model
	// computes it.
	typedef struct packed {
		date_req_t rq;
		logic      typed;
		date_res_t lit;
	} dir_row_t;

	localparam int NUM_DIRECTED = 26;

	localparam dir_row_t DIRECTED_TAB [NUM_DIRECTED] = '{
		// These start dates are malformed. Every operation echoes them with the invalid status.
		'{'{FUNC_ADD_DAYS,   14'd2024,  4'd0,  5'd15, 16'd5},     1'b1,
			'{14'd2024,  4'd0,  5'd15, STATUS_INVALID}},
		'{'{FUNC_ADD_MONTHS, 14'd2024,  4'd13, 5'd1,  16'd1},     1'b1,
			'{14'd2024,  4'd13, 5'd1,  STATUS_INVALID}},
		'{'{FUNC_ADD_YEARS,  14'd2024,  4'd15, 5'd31, 16'd7},     1'b1,
			'{14'd2024,  4'd15, 5'd31, STATUS_INVALID}},
		'{'{FUNC_ADD_DAYS,   14'd2024,  4'd6,  5'd0,  16'd3},     1'b1,
			'{14'd2024,  4'd6,  5'd0,  STATUS_INVALID}},
		'{'{FUNC_ADD_DAYS,   14'd2023,  4'd2,  5'd29, 16'd1},     1'b1,
			'{14'd2023,  4'd2,  5'd29, STATUS_INVALID}},
		'{'{FUNC_ADD_YEARS,  14'd1900,  4'd2,  5'd29, 16'd1},     1'b1,
			'{14'd1900,  4'd2,  5'd29, STATUS_INVALID}},
		'{'{FUNC_ADD_DAYS,   14'd2024,  4'd4,  5'd31, 16'd0},     1'b1,
			'{14'd2024,  4'd4,  5'd31, STATUS_INVALID}},
		// The start year is past the maximum.
		'{'{FUNC_ADD_DAYS,   14'd10000, 4'd3,  5'd1,  16'd1},     1'b1,
			'{14'd10000, 4'd3,  5'd1,  STATUS_OVERFLOW}},
		'{'{FUNC_ADD_MONTHS, 14'd16383, 4'd12, 5'd31, 16'd65535}, 1'b1,
			'{14'd16383, 4'd12, 5'd31, STATUS_OVERFLOW}},
		// The unused operation code gives an echo with the ok status, but the date check still applies.
		'{'{FUNC_UNUSED,     14'd2024,  4'd6,  5'd15, 16'd100},   1'b1,
			'{14'd2024,  4'd6,  5'd15, STATUS_OK}},
		'{'{FUNC_UNUSED,     14'd16383, 4'd15, 5'd31, 16'd65535}, 1'b1,
			'{14'd16383, 4'd15, 5'd31, STATUS_INVALID}},
		// These day additions cover month and year edges under the leap-year rules, a zero amount and the year limit.
		'{'{FUNC_ADD_DAYS,   14'd2000,  4'd2,  5'd29, 16'd1},     1'b1,
			'{14'd2000,  4'd3,  5'd1,  STATUS_OK}},
		'{'{FUNC_ADD_DAYS,   14'd1999,  4'd12, 5'd31, 16'd1},     1'b1,
			'{14'd2000,  4'd1,  5'd1,  STATUS_OK}},
		'{'{FUNC_ADD_DAYS,   14'd2100,  4'd2,  5'd28, 16'd1},     1'b1,
			'{14'd2100,  4'd3,  5'd1,  STATUS_OK}},
		'{'{FUNC_ADD_DAYS,   14'd2024,  4'd1,  5'd1,  16'd0},     1'b1,
			'{14'd2024,  4'd1,  5'd1,  STATUS_OK}},
		'{'{FUNC_ADD_DAYS,   14'd0,     4'd1,  5'd1,  16'd65535}, 1'b0, '0},
		'{'{FUNC_ADD_DAYS,   14'd9999,  4'd12, 5'd31, 16'd1},     1'b1,
			'{14'd9999,  4'd12, 5'd31, STATUS_OVERFLOW}},
		'{'{FUNC_ADD_DAYS,   14'd9850,  4'd1,  5'd1,  16'd65535}, 1'b0, '0},
		'{'{FUNC_ADD_DAYS,   14'd9000,  4'd6,  5'd15, 16'd65535}, 1'b0, '0},
		// Month additions keep the day, even when that day does not exist in the new month.
		'{'{FUNC_ADD_MONTHS, 14'd2024,  4'd1,  5'd31, 16'd1},     1'b1,
			'{14'd2024,  4'd2,  5'd31, STATUS_OK}},
		'{'{FUNC_ADD_MONTHS, 14'd2023,  4'd11, 5'd15, 16'd2},     1'b1,
			'{14'd2024,  4'd1,  5'd15, STATUS_OK}},
		'{'{FUNC_ADD_MONTHS, 14'd2000,  4'd1,  5'd1,  16'd65535}, 1'b0, '0},
		'{'{FUNC_ADD_MONTHS, 14'd9999,  4'd12, 5'd1,  16'd1},     1'b1,
			'{14'd9999,  4'd12, 5'd1,  STATUS_OVERFLOW}},
		// Year additions. Year zero is a leap year, so its February 29 is valid.
		'{'{FUNC_ADD_YEARS,  14'd0,     4'd2,  5'd29, 16'd9999},  1'b1,
			'{14'd9999,  4'd2,  5'd29, STATUS_OK}},
		'{'{FUNC_ADD_YEARS,  14'd0,     4'd1,  5'd1,  16'd65535}, 1'b1,
			'{14'd0,     4'd1,  5'd1,  STATUS_OVERFLOW}},
		'{'{FUNC_ADD_YEARS,  14'd2024,  4'd7,  5'd4,  16'd0},     1'b1,
			'{14'd2024,  4'd7,  5'd4,  STATUS_OK}}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         func = '0;
	logic [YEAR_W-1:0]  start_year = '0;
	logic [MONTH_W-1:0] start_month = '0;
	logic [DAY_W-1:0]   start_day = '0;
	logic [AMT_W-1:0]   amount = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [YEAR_W-1:0]  result_year;
	logic [MONTH_W-1:0] result_month;
	logic [DAY_W-1:0]   result_day;
	logic [STAT_W-1:0]  status;

	// While calm is set, neither side idles at random.
	logic calm = 1'b0;

	date_res_t due_dates[$];
	int        n_bad = 0;
	int        n_checked = 0;
	int        n_by_op[4] = '{0, 0, 0, 0};
	int        n_by_status[4] = '{0, 0, 0, 0};
	longint    cycles = 0;

	gregorian_date_adder #(
		.AMOUNT_BITS(AMT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.start_year(start_year),
		.start_month(start_month),
		.start_day(start_day),
		.amount(amount),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.result_year(result_year),
		.result_month(result_month),
		.result_day(result_day),
		.status(status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			2:                     return is_leap(y) ? 29 : 28;
			default:               return 30;
		endcase
	endfunction

	// This function computes the result date and status for one request.
	function automatic date_res_t predict_date(input date_req_t rq);
		int unsigned       y;
		int unsigned       m;
		int unsigned       d;
		int unsigned       left;
		logic [STAT_W-1:0] st;
		date_res_t         res;
		y = rq.year;
		m = rq.month;
		d = rq.day;
		st = STATUS_OK;
		if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
			st = STATUS_INVALID;
		end else if (y > MAX_YEAR) begin
			st = STATUS_OVERFLOW;
		end else begin
			case (rq.op)
				FUNC_ADD_DAYS: begin
					// Use up the rest of each month until the amount fits in the current one.
					left = rq.amount;
					while (st == STATUS_OK && days_in_month(y, m) - d < left) begin
						left -= days_in_month(y, m) - d;
						d = 0;
						m++;
						if (m > 12) begin
							m = 1;
							y++;
							if (y > MAX_YEAR)
								st = STATUS_OVERFLOW;
						end
					end
					d += left;
				end
				FUNC_ADD_MONTHS: begin
					y += rq.amount / 12;
					m += rq.amount % 12;
					if (m > 12) begin
						y++;
						m -= 12;
					end
					if (y > MAX_YEAR)
						st = STATUS_OVERFLOW;
				end
				FUNC_ADD_YEARS: begin
					y += rq.amount;
					if (y > MAX_YEAR)
						st = STATUS_OVERFLOW;
				end
				default: begin
				end
			endcase
		end
		if (st != STATUS_OK) begin
			y = rq.year;
			m = rq.month;
			d = rq.day;
		end
		res.year  = YEAR_W'(y);
		res.month = MONTH_W'(m);
		res.day   = DAY_W'(d);
		res.stat  = st;
		return res;
	endfunction

	// This task offers one request item, holds it until it is accepted, and then
	// queues its expected result. Every drive happens just after a rising edge.
	// When the next item follows at once, req_valid gets only its one assignment.
	// With hold_off set, the request side first waits until every queued result
	// has come back.
	task automatic send_request(input date_req_t rq, input date_res_t want, input bit hold_off);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < 22)
				gap++;
		end
		if (hold_off && gap == 0)
			gap = 1;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (hold_off && due_dates.size() != 0)
				@(posedge clk);
		end
		func        <= rq.op;
		start_year  <= rq.year;
		start_month <= rq.month;
		start_day   <= rq.day;
		amount      <= rq.amount;
		req_valid   <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		due_dates.push_back(want);
		n_by_op[rq.op]++;
	endtask

	initial begin : stimulus
		date_req_t rq;
		int        pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table. A row without a typed-in result goes to the model.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			rq = DIRECTED_TAB[i].rq;
			send_request(rq, DIRECTED_TAB[i].typed ? DIRECTED_TAB[i].lit : predict_date(rq),
				1'b0);
		end

		// Most random items are well-formed dates with ordinary amounts. A few use
		// years near the limit or full-width amounts. About one in eight is raw noise
		// over every bit of every field. Full-width day amounts are kept rare because
		// each one can walk up to about 2200 months.
		for (int i = 0; i < NUM_RANDOM; i++) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				rq.op     = 2'($urandom);
				rq.year   = YEAR_W'($urandom);
				rq.month  = MONTH_W'($urandom);
				rq.day    = DAY_W'($urandom);
				rq.amount = AMT_W'($urandom);
			end else begin
				rq.op = ($urandom_range(99) < 4) ? FUNC_UNUSED : 2'($urandom_range(2));
				rq.year = ($urandom_range(9) == 0) ? YEAR_W'($urandom_range(9999, 9800))
				                                   : YEAR_W'($urandom_range(9999));
				rq.month = MONTH_W'($urandom_range(12, 1));
				rq.day = DAY_W'($urandom_range(days_in_month(rq.year, rq.month), 1));
				case (rq.op)
					FUNC_ADD_DAYS:
						rq.amount = ($urandom_range(29) == 0) ? AMT_W'($urandom)
						                                      : AMT_W'($urandom_range(1500));
					FUNC_ADD_MONTHS, FUNC_ADD_YEARS:
						rq.amount = ($urandom_range(9) == 0) ? AMT_W'($urandom)
						                                     : AMT_W'($urandom_range(400));
					default:
						rq.amount = AMT_W'($urandom);
				endcase
			end
			// The calm stretch runs from item 80 to item 139 of the random part.
			if (i == 80)
				calm <= 1'b1;
			if (i == 140)
				calm <= 1'b0;
			send_request(rq, predict_date(rq), i == 0 || i == 120);
		end
		req_valid <= 1'b0;

		while (due_dates.size() != 0)
			@(posedge clk);
		// This wait gives a stray extra result time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d add-days, %0d add-months, %0d add-years, %0d unused op.",
			NUM_DIRECTED + NUM_RANDOM, n_by_op[FUNC_ADD_DAYS], n_by_op[FUNC_ADD_MONTHS],
			n_by_op[FUNC_ADD_YEARS], n_by_op[FUNC_UNUSED]);
		$display("Checked %0d results: %0d ok, %0d invalid start, %0d overflow; %0d bad fields.",
			n_checked, n_by_status[STATUS_OK], n_by_status[STATUS_INVALID],
			n_by_status[STATUS_OVERFLOW], n_bad);
		if (n_bad == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The receiver stalls at random, except during the calm stretch.
	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 22);
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_bad++;
		end
	endtask

	// Each accepted result item is compared with the oldest queued result.
	always @(posedge clk) begin : check_results
		date_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (due_dates.size() == 0) begin
				$error("result item with nothing queued: %0d-%0d-%0d status %0d",
					result_year, result_month, result_day, status);
				n_bad++;
			end else begin
				want = due_dates.pop_front();
				check_field("result_year", want.year, result_year);
				check_field("result_month", want.month, result_month);
				check_field("result_day", want.day, result_day);
				check_field("status", want.stat, status);
				n_checked++;
				n_by_status[status]++;
			end
		end
	end

	// The watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

### gregorian_date_adder.f
rtl/gda_pkg.sv
rtl/gda_ctrl.sv
rtl/gda_dp.sv
rtl/gregorian_date_adder.sv
tb/tb_top.sv
